FILE: src/utf8_codepoint_decoder_macros.svh
// Assertion macros for the UTF-8 code point decoder.
// Used by the top level only; no other dependencies.
`ifndef UTF8_CODEPOINT_DECODER_MACROS_SVH
`define UTF8_CODEPOINT_DECODER_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define UCD_ASSERT_SAME(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("ucd assertion failed");

// Check that a condition implies a consequence in the next cycle
`define UCD_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("ucd assertion failed");

`endif

FILE: src/ucd_pkg.sv
// Shared types and constants for the UTF-8 code point decoder.
// No dependencies; imported by ucd_step and utf8_codepoint_decoder.
package ucd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned OwedW  = 2;
  localparam int unsigned OutDataW = ((CpW + 7) / 8) * 8;

  // Lead byte patterns and masks
  localparam logic [ByteW-1:0] ASCII_MASK  = 8'b1000_0000;
  localparam logic [ByteW-1:0] LEAD2_MASK  = 8'b1110_0000;
  localparam logic [ByteW-1:0] LEAD2_CODE  = 8'b1100_0000;
  localparam logic [ByteW-1:0] LEAD3_MASK  = 8'b1111_0000;
  localparam logic [ByteW-1:0] LEAD3_CODE  = 8'b1110_0000;
  localparam logic [ByteW-1:0] CONT_BITS   = 8'b0011_1111;
  localparam logic [ByteW-1:0] LEAD2_BITS  = 8'b0001_1111;
  localparam logic [ByteW-1:0] LEAD3_BITS  = 8'b0000_1111;
  localparam logic [ByteW-1:0] LEAD4_BITS  = 8'b0000_0111;

  // Continuation bytes still expected
  localparam logic [OwedW-1:0] OWED_NONE  = 2'd0;
  localparam logic [OwedW-1:0] OWED_ONE   = 2'd1;
  localparam logic [OwedW-1:0] OWED_TWO   = 2'd2;
  localparam logic [OwedW-1:0] OWED_THREE = 2'd3;

  // Result status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_TRUNCATED = 1'b1;

  typedef struct packed {
    logic [CpW-1:0]   partial_value;
    logic [OwedW-1:0] bytes_owed;
  } dec_state_t;

  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] code_point;
    logic           status;
  } dec_result_t;

endpackage

FILE: src/ucd_step.sv
// Next-state and result logic for one byte of the UTF-8 decoder.
// Depends on ucd_pkg.
module ucd_step
  import ucd_pkg::*;
(
  input  logic [ByteW-1:0] data_byte,
  input  logic             end_of_string,
  input  dec_state_t       state,
  output dec_state_t       state_next,
  output dec_result_t      result
);

  logic [CpW-1:0]   shifted;
  logic [OwedW-1:0] owed_dec;

  assign shifted  = {state.partial_value[CpW-7:0], data_byte[5:0]};
  assign owed_dec = state.bytes_owed - OWED_ONE;

  always_comb begin
    state_next        = state;
    result.emit       = 1'b0;
    result.code_point = '0;
    result.status     = STATUS_OK;

    if (state.bytes_owed == OWED_NONE) begin
      // Decode the lead byte
      if ((data_byte & ASCII_MASK) == '0) begin
        state_next.partial_value = '0;
        result.emit              = 1'b1;
        result.code_point        = {{(CpW-ByteW){1'b0}}, data_byte};
      end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
        state_next.partial_value = {{(CpW-ByteW){1'b0}}, data_byte & LEAD2_BITS};
        state_next.bytes_owed    = OWED_ONE;
      end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
        state_next.partial_value = {{(CpW-ByteW){1'b0}}, data_byte & LEAD3_BITS};
        state_next.bytes_owed    = OWED_TWO;
      end else begin
        // Stray continuation and 11111xxx both count as a 4-byte lead
        state_next.partial_value = {{(CpW-ByteW){1'b0}}, data_byte & LEAD4_BITS};
        state_next.bytes_owed    = OWED_THREE;
      end
    end else begin
      // Shift in six payload bits of a continuation byte
      state_next.partial_value = shifted;
      state_next.bytes_owed    = owed_dec;
      if (owed_dec == OWED_NONE) begin
        state_next.partial_value = '0;
        result.emit              = 1'b1;
        result.code_point        = shifted;
      end
    end

    // String ended mid-sequence: report truncation and go idle
    if (!result.emit && end_of_string) begin
      state_next.partial_value = '0;
      state_next.bytes_owed    = OWED_NONE;
      result.emit              = 1'b1;
      result.code_point        = '0;
      result.status            = STATUS_TRUNCATED;
    end
  end

endmodule

FILE: src/utf8_codepoint_decoder.sv
// UTF-8 code point decoder top level: state register, result register, skid stage.
// Depends on ucd_pkg, ucd_step and utf8_codepoint_decoder_macros.svh.
//
// Usage:
//   Input stream s_axis carries one string byte per transfer in tdata, with
//   tlast on the string's last byte. Output stream m_axis carries one decoded
//   code point per transfer in tdata and a status bit in tuser (0 complete,
//   1 sequence cut short by the end of the string; code point then zero).
//   A byte is taken every cycle while s_axis_tready is high: 1 byte/cycle.
//   A byte that completes a sequence (or ends a string mid-sequence) has its
//   result taken into the output register, or into the skid register on a stall.
//   Other bytes only update the partial code point and the count of
//   continuation bytes still owed; they produce no transfer.
//   When the receiver stalls, results collect in the output register and
//   one skid register; s_axis_tready drops only while the skid register is
//   full, and it is a register output, so no path runs from m_axis_tready
//   to s_axis_tready.
//   Reset (rst, synchronous, active high) clears the partial value, the owed
//   count and the valid flags of both result registers.
`include "utf8_codepoint_decoder_macros.svh"

module utf8_codepoint_decoder
  import ucd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic                s_axis_tlast,   // end_of_string
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [20:0] code_point, upper bits zero
  output logic                m_axis_tuser    // status
);

  dec_state_t  state;
  dec_state_t  state_next;
  dec_result_t step_result;

  logic           out_valid;
  logic [CpW-1:0] out_code_point;
  logic           out_status;
  logic           skid_valid;
  logic [CpW-1:0] skid_code_point;
  logic           skid_status;

  logic in_xfer;
  logic out_xfer;
  logic new_result;

  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_xfer   = out_valid && m_axis_tready;
  assign new_result = in_xfer && step_result.emit;

  ucd_step u_step (
    .data_byte     (s_axis_tdata),
    .end_of_string (s_axis_tlast),
    .state         (state),
    .state_next    (state_next),
    .result        (step_result)
  );

  // Advance decoder state on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_xfer) begin
      state <= state_next;
    end
  end

  // Output register fed by the skid register first, then the new result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_xfer) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= new_result;
        end else begin
          out_valid  <= new_result;
        end
      end else if (new_result) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!out_valid || out_xfer) begin
      if (skid_valid) begin
        out_code_point <= skid_code_point;
        out_status     <= skid_status;
      end else if (new_result) begin
        out_code_point <= step_result.code_point;
        out_status     <= step_result.status;
      end
    end
    if (new_result && (skid_valid || (out_valid && !out_xfer))) begin
      skid_code_point <= step_result.code_point;
      skid_status     <= step_result.status;
    end
  end

  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OutDataW-CpW){1'b0}}, out_code_point};
  assign m_axis_tuser  = out_status;

  // Assertions
  `UCD_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `UCD_ASSERT_SAME(a_trunc_zero_cp, clk, rst, out_valid && out_status, out_code_point == '0)
  `UCD_ASSERT_NEXT(a_last_clears_owed, clk, rst, in_xfer && s_axis_tlast,
                   state.bytes_owed == OWED_NONE)
  `UCD_ASSERT_NEXT(a_stall_keeps_skid, clk, rst, skid_valid && !out_xfer, skid_valid)

endmodule
